@@ src/psc_pkg.sv @@
// shared types, constants and helpers of the plane sweep cost select unit
package psc_pkg;

   localparam int SAD_W         = 14;
   localparam int COST_W        = 10;
   localparam int PLANE_W       = 8;
   localparam int DEPTH_W       = 16;
   localparam int PCOUNT_W      = 9;
   localparam int VIEWS_FIELD_W = 7;
   localparam int DIV_NUM_W     = 25;
   localparam int DIV_DEN_W     = 9;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = 2;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic [SAD_W-1:0]  SAD_LIMIT  = 14'd16383;
   localparam logic [COST_W-1:0] FULL_COST  = 10'd765;
   localparam logic [COST_W-1:0] HALF_LIMIT = 10'd382;

   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_DEPTH_FAR  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_DEPTH_NEAR = 2'd2;

   typedef struct packed {
      logic [SAD_W-1:0]         sad;
      logic [VIEWS_FIELD_W-1:0] views;
      logic                     last_plane;
   } plane_rec_type;

   typedef struct packed {
      logic [PCOUNT_W-1:0] plane_count;
      logic [DEPTH_W-1:0]  inv_depth_far;
      logic [DEPTH_W-1:0]  inv_depth_near;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d;
   endfunction

endpackage

@@ src/psc_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module psc_div (
   input  logic                clock,
   input  logic                reset,
   input  psc_pkg::div_req_type div_req,
   output psc_pkg::div_rsp_type div_rsp
);
   import psc_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_NUM_W-1:0] quot_ff;
   logic [DIV_DEN_W-1:0] den_ff;

   logic [DIV_DEN_W:0]   trial;
   logic                 fits;
   logic [DIV_DEN_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, quot_ff[DIV_NUM_W-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quot_ff <= div_req.dividend;
         rem_ff  <= '0;
         den_ff  <= div_req.divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[DIV_NUM_W-2:0], fits};
         rem_ff  <= rem_in;
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      !(div_req.start && busy_ff))
      else $error("divider started while busy");

endmodule

@@ src/psc_front.sv @@
// front: accepts words, accumulates per-plane sad of valid views
module psc_front #(
   parameter int MAX_VIEWS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_ref_red,
   input  logic [7:0]            req_ref_green,
   input  logic [7:0]            req_ref_blue,
   input  logic [7:0]            req_warp_red,
   input  logic [7:0]            req_warp_green,
   input  logic [7:0]            req_warp_blue,
   input  logic                  req_warp_inside,
   input  logic                  req_last_view,
   input  logic                  req_last_plane,
   input  logic                  queue_full,
   output logic                  push,
   output psc_pkg::plane_rec_type push_rec
);
   import psc_pkg::*;

   localparam int VW = $clog2(MAX_VIEWS + 1);

   logic [SAD_W-1:0] sad_ff,   sad_in;
   logic [VW-1:0]    views_ff, views_in;

   logic             accept;
   logic             take;
   logic [9:0]       err;
   logic [SAD_W:0]   sum;
   logic [SAD_W-1:0] sad_upd;
   logic [VW-1:0]    views_upd;

   always_comb begin
      req_ready = !queue_full;
      accept    = req_valid && req_ready;
      take      = accept && req_warp_inside && (views_ff < VW'(MAX_VIEWS));
      err       = 10'(abs_diff(req_ref_red, req_warp_red))
                + 10'(abs_diff(req_ref_green, req_warp_green))
                + 10'(abs_diff(req_ref_blue, req_warp_blue));
      sum       = {1'b0, sad_ff} + (SAD_W + 1)'(err);
      sad_upd   = sad_ff;
      views_upd = views_ff;
      if (take) begin
         sad_upd   = (sum > {1'b0, SAD_LIMIT}) ? SAD_LIMIT : sum[SAD_W-1:0];
         views_upd = views_ff + 1'b1;
      end
      push                = accept && req_last_view;
      push_rec.sad        = sad_upd;
      push_rec.views      = VIEWS_FIELD_W'(views_upd);
      push_rec.last_plane = req_last_plane;
      // end of plane empties the accumulator
      sad_in   = push ? '0 : sad_upd;
      views_in = push ? '0 : views_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sad_ff   <= '0;
         views_ff <= '0;
      end else begin
         sad_ff   <= sad_in;
         views_ff <= views_in;
      end
   end

endmodule

@@ src/psc_fifo.sv @@
// short queue of per-plane records between front and back
module psc_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  psc_pkg::plane_rec_type push_rec,
   input  logic                  pop,
   output psc_pkg::plane_rec_type head_rec,
   output logic                  empty,
   output logic                  full
);
   import psc_pkg::*;

   plane_rec_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]       count_ff;

   always_comb begin
      empty    = count_ff == '0;
      full     = count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
      head_rec = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_rec;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

endmodule

@@ src/psc_back.sv @@
// back: plane cost division, winner selection, interpolation and result register
module psc_back #(
   parameter int MAX_PLANES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  psc_pkg::cfg_type       cfg,
   input  psc_pkg::plane_rec_type head_rec,
   input  logic                  queue_empty,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_best_plane,
   output logic                  rsp_plane_found,
   output logic [15:0]           rsp_inverse_depth,
   output logic [9:0]            rsp_confidence_cost,
   output logic                  rsp_depth_accepted
);
   import psc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_COST  = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_ILOAD = 6'b001000,
      ST_IDIV  = 6'b010000,
      ST_EMIT  = 6'b100000
   } back_state_type;

   back_state_type        state_ff, state_in;
   logic [COST_W-1:0]     best_cost_ff;
   logic [PLANE_W-1:0]    best_index_ff;
   logic                  best_seen_ff;
   logic [PLANE_W-1:0]    plane_ff;
   logic                  views_nz_ff;
   logic                  last_plane_ff;
   logic [DIV_NUM_W-1:0]  num_ff;
   logic [DEPTH_W-1:0]    depth_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            best_plane_ff;
   logic                  plane_found_ff;
   logic [15:0]           inverse_depth_ff;
   logic [9:0]            confidence_ff;
   logic                  accepted_ff;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic                  improve;
   logic                  out_free;
   logic                  accepted;
   logic                  rising;
   logic [PCOUNT_W-1:0]   den;
   logic [DEPTH_W-1:0]    span;
   logic [DIV_NUM_W-1:0]  num_in;
   logic [DIV_NUM_W-1:0]  q;
   logic [DEPTH_W:0]      up_sum;
   logic [DEPTH_W-1:0]    depth_in;
   logic [PLANE_W-1:0]    plane_next;

   psc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      pop      = (state_ff == ST_IDLE) && !queue_empty;
      improve  = views_nz_ff && (div_rsp.quotient < DIV_NUM_W'(best_cost_ff));
      accepted = best_seen_ff && (best_cost_ff <= HALF_LIMIT);

      // interpolation: |near - far| * index + den/2, divided by den
      den    = (cfg.plane_count < PCOUNT_W'(2)) ? PCOUNT_W'(1)
                                                : cfg.plane_count - 1'b1;
      rising = cfg.inv_depth_near >= cfg.inv_depth_far;
      span   = rising ? cfg.inv_depth_near - cfg.inv_depth_far
                      : cfg.inv_depth_far - cfg.inv_depth_near;
      num_in = DIV_NUM_W'(span) * DIV_NUM_W'(best_index_ff) + DIV_NUM_W'(den >> 1);

      q      = div_rsp.quotient;
      up_sum = {1'b0, cfg.inv_depth_far} + (DEPTH_W + 1)'(q[DEPTH_W-1:0]);
      if (rising) begin
         depth_in = ((q > DIV_NUM_W'(16'hFFFF)) || up_sum[DEPTH_W]) ? 16'hFFFF
                                                                  : up_sum[DEPTH_W-1:0];
      end else begin
         depth_in = (q >= DIV_NUM_W'(cfg.inv_depth_far)) ? '0
                                                         : cfg.inv_depth_far - q[DEPTH_W-1:0];
      end

      // plane counter wraps at the plane limit within its width
      if (MAX_PLANES < (1 << PLANE_W) && plane_ff == PLANE_W'(MAX_PLANES - 1))
         plane_next = '0;
      else
         plane_next = plane_ff + 1'b1;

      div_req.start    = pop || (state_ff == ST_ILOAD);
      div_req.dividend = (state_ff == ST_ILOAD) ? num_ff : DIV_NUM_W'(head_rec.sad);
      div_req.divisor  = (state_ff == ST_ILOAD) ? DIV_DEN_W'(den)
                                                : DIV_DEN_W'(head_rec.views);

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (pop) state_in = ST_COST;
         ST_COST:  if (div_rsp.done) state_in = last_plane_ff ? ST_MUL : ST_IDLE;
         ST_MUL:   state_in = ST_ILOAD;
         ST_ILOAD: state_in = ST_IDIV;
         ST_IDIV:  if (div_rsp.done) state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         best_cost_ff  <= FULL_COST;
         best_index_ff <= '0;
         best_seen_ff  <= 1'b0;
         plane_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_COST && div_rsp.done) begin
            if (improve) begin
               best_cost_ff  <= COST_W'(div_rsp.quotient);
               best_index_ff <= plane_ff;
               best_seen_ff  <= 1'b1;
            end
            if (!last_plane_ff) plane_ff <= plane_next;
         end
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff  <= 1'b1;
            best_cost_ff  <= FULL_COST;
            best_index_ff <= '0;
            best_seen_ff  <= 1'b0;
            plane_ff      <= '0;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         views_nz_ff   <= head_rec.views != '0;
         last_plane_ff <= head_rec.last_plane;
      end
      if (state_ff == ST_MUL) num_ff <= num_in;
      if (state_ff == ST_IDIV && div_rsp.done) depth_ff <= depth_in;
      if (state_ff == ST_EMIT && out_free) begin
         best_plane_ff    <= best_seen_ff ? best_index_ff : '0;
         plane_found_ff   <= best_seen_ff;
         inverse_depth_ff <= accepted ? depth_ff : '0;
         confidence_ff    <= best_seen_ff ? best_cost_ff : FULL_COST;
         accepted_ff      <= accepted;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_best_plane      = best_plane_ff;
   assign rsp_plane_found     = plane_found_ff;
   assign rsp_inverse_depth   = inverse_depth_ff;
   assign rsp_confidence_cost = confidence_ff;
   assign rsp_depth_accepted  = accepted_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("back state not one-hot");

   a_seen_below_full: assert property (@(posedge clock) disable iff (reset)
      best_seen_ff |-> (best_cost_ff < FULL_COST))
      else $error("winner recorded without a cost below full scale");

endmodule

@@ src/plane_sweep_cost_select_unit.sv @@
// top level of the plane sweep cost select unit
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid / req_ready | one (plane, view) sample pair
//   rsp     | out       | rsp_valid / rsp_ready | winner of one pixel
//   csr     | in        | csr_write             | register index and data
//
// front takes one req word per cycle while the plane queue has room
// each plane costs the back one queue pop, 25 steps of the shared divider for
//   sad / views, and a winner update
// the last plane of a pixel adds a multiply, a second pass of the same divider
//   for the interpolation, and the result register load
// reset clears the accumulator, the queue, the winner state and the result
//   valid flag; registers return to 64 planes, far 0, near 65535
// a stalled rsp holds the back at its result load only; the front keeps going
//   until the four-entry plane queue fills
module plane_sweep_cost_select_unit #(
   parameter int MAX_PLANES = 256,
   parameter int MAX_VIEWS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   // sample input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ref_red,
   input  logic [7:0]  req_ref_green,
   input  logic [7:0]  req_ref_blue,
   input  logic [7:0]  req_warp_red,
   input  logic [7:0]  req_warp_green,
   input  logic [7:0]  req_warp_blue,
   input  logic        req_warp_inside,
   input  logic        req_last_view,
   input  logic        req_last_plane,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_best_plane,
   output logic        rsp_plane_found,
   output logic [15:0] rsp_inverse_depth,
   output logic [9:0]  rsp_confidence_cost,
   output logic        rsp_depth_accepted,
   // register writes
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import psc_pkg::*;

   // configuration registers
   cfg_type       cfg_ff;

   // front to queue to back
   logic          push;
   plane_rec_type push_rec;
   plane_rec_type head_rec;
   logic          pop;
   logic          queue_empty;
   logic          queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plane_count    <= PCOUNT_W'(64);
         cfg_ff.inv_depth_far  <= '0;
         cfg_ff.inv_depth_near <= 16'hFFFF;
      end else if (csr_write) begin
         // unknown indexes are dropped
         unique case (csr_index)
            CSR_PLANE_COUNT:    cfg_ff.plane_count    <= csr_data[PCOUNT_W-1:0];
            CSR_INV_DEPTH_FAR:  cfg_ff.inv_depth_far  <= csr_data[DEPTH_W-1:0];
            CSR_INV_DEPTH_NEAR: cfg_ff.inv_depth_near <= csr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // front: per-word sad accumulation, one record per plane
   psc_front #(
      .MAX_VIEWS (MAX_VIEWS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ref_red     (req_ref_red),
      .req_ref_green   (req_ref_green),
      .req_ref_blue    (req_ref_blue),
      .req_warp_red    (req_warp_red),
      .req_warp_green  (req_warp_green),
      .req_warp_blue   (req_warp_blue),
      .req_warp_inside (req_warp_inside),
      .req_last_view   (req_last_view),
      .req_last_plane  (req_last_plane),
      .queue_full      (queue_full),
      .push            (push),
      .push_rec        (push_rec)
   );

   // decoupling queue of plane records
   psc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // back: cost, winner, inverse depth, result register
   psc_back #(
      .MAX_PLANES (MAX_PLANES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .head_rec            (head_rec),
      .queue_empty         (queue_empty),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_best_plane      (rsp_best_plane),
      .rsp_plane_found     (rsp_plane_found),
      .rsp_inverse_depth   (rsp_inverse_depth),
      .rsp_confidence_cost (rsp_confidence_cost),
      .rsp_depth_accepted  (rsp_depth_accepted)
   );

endmodule
